[hdl/adpf_pkg.sv]
// ----------------------------------------------------------------------------
// adpf_pkg: shared types and constants of the DC blocker and framer
// Holds configuration codes, the queue entry format, state types and the
// 16-bit saturation helper.
// ----------------------------------------------------------------------------
package adpf_pkg;

  localparam int FrameLenDef = 64;
  localparam int HopLenDef   = 32;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [15:0] DcAlphaReset     = 16'd65472;
  localparam logic [15:0] PreemphCoefReset = 16'd63570;

  localparam int          SinceW   = 7;
  localparam logic [6:0]  SinceMax = 7'd127;

  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDcAlpha       = 2'd0,
    CfgPreemphEnable = 2'd1,
    CfgPreemphCoef   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               due;
  } q_entry_t;

  typedef enum logic [1:0] {
    FrIdle,
    FrMul,
    FrSum,
    FrPush
  } fr_state_e;

  typedef enum logic {
    BkIdle,
    BkEmit
  } bk_state_e;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hdl/adpf_if.sv]
// ----------------------------------------------------------------------------
// adpf_if: request channels of the DC blocker and framer
// Sample input channel and windowed frame output channel, valid/ready.
// ----------------------------------------------------------------------------
interface adpf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               last_in_block;

  modport source (output valid, output sample_in, output last_in_block, input ready);
  modport sink (input valid, input sample_in, input last_in_block, output ready);
endinterface

interface adpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] win_sample;
  logic [5:0]         frame_index;
  logic               frame_last;

  modport source (output valid, output win_sample, output frame_index,
                  output frame_last, input ready);
  modport sink (input valid, input win_sample, input frame_index,
                input frame_last, output ready);
endinterface

[hdl/adpf_front.sv]
// ----------------------------------------------------------------------------
// adpf_front: sample conditioning front end
// Removes the tracked DC level, applies optional pre-emphasis, keeps the fill
// and hop counters and tags each conditioned sample with a frame-due flag.
// ----------------------------------------------------------------------------
module adpf_front import adpf_pkg::*; #(
  parameter int FRAME_LEN = FrameLenDef,
  parameter int HOP_LEN   = HopLenDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_wr_t  cfg_i,
  adpf_in_if.sink  in_i,
  output q_entry_t push_data_o,
  output logic     push_valid_o,
  input  logic     push_ready_i
);

  localparam int FillW = $clog2(FRAME_LEN + 1);

  fr_state_e state_q, state_d;

  logic [15:0] alpha_q, coef_q;
  logic        pre_en_q;

  logic signed [15:0] x_q;
  logic               last_q;
  logic signed [40:0] prod_a_q;
  logic signed [41:0] prod_b_q;
  logic signed [33:0] prod_c_q;
  logic signed [23:0] dc_q;
  logic signed [16:0] prior_q;
  logic [FillW-1:0]   fill_q;
  logic [SinceW-1:0]  since_q;

  logic [16:0]        one_minus;
  logic signed [23:0] x8;
  logic signed [42:0] dc_sum;
  logic signed [24:0] diff;
  logic signed [16:0] y;
  logic signed [18:0] y_ext;
  logic signed [18:0] pc_term;
  logic signed [18:0] e;
  logic [FillW-1:0]   fill_n;
  logic [SinceW-1:0]  since_n;
  logic               due;
  logic               accept;
  logic               push;

  assign one_minus = 17'h10000 - {1'b0, alpha_q};
  assign x8        = {x_q, 8'h00};
  assign dc_sum    = {{2{prod_a_q[40]}}, prod_a_q} + {prod_b_q[41], prod_b_q};
  assign diff      = {x8[23], x8} - {dc_q[23], dc_q};
  assign y         = diff[24:8];
  assign y_ext     = {{2{y[16]}}, y};
  assign pc_term   = pre_en_q ? {prod_c_q[33], prod_c_q[33:16]} : '0;
  assign e         = y_ext - pc_term;

  assign fill_n  = (fill_q < FillW'(FRAME_LEN)) ? fill_q + 1'b1 : fill_q;
  assign since_n = (since_q < SinceMax) ? since_q + 1'b1 : since_q;
  assign due     = last_q && (fill_n == FillW'(FRAME_LEN)) &&
                   (since_n >= SinceW'(HOP_LEN));

  assign accept = in_i.valid && in_i.ready;
  assign push   = push_valid_o && push_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FrIdle: begin
        if (in_i.valid) begin
          state_d = FrMul;
        end
      end
      FrMul:  state_d = FrSum;
      FrSum:  state_d = FrPush;
      FrPush: begin
        if (push_ready_i) begin
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  always_comb begin
    in_i.ready         = (state_q == FrIdle);
    push_valid_o       = (state_q == FrPush);
    push_data_o.sample = sat16(32'(e));
    push_data_o.due    = due;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FrIdle;
      alpha_q  <= DcAlphaReset;
      coef_q   <= PreemphCoefReset;
      pre_en_q <= 1'b0;
      dc_q     <= '0;
      prior_q  <= '0;
      fill_q   <= '0;
      since_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.we) begin
        case (cfg_i.index)
          CfgDcAlpha:       alpha_q  <= cfg_i.data;
          CfgPreemphEnable: pre_en_q <= cfg_i.data[0];
          CfgPreemphCoef:   coef_q   <= cfg_i.data;
          default: ;
        endcase
      end
      if (state_q == FrSum) begin
        dc_q <= dc_sum[39:16];
      end
      if (push) begin
        fill_q  <= fill_n;
        since_q <= due ? since_n - SinceW'(HOP_LEN) : since_n;
        if (pre_en_q) begin
          prior_q <= y;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= in_i.sample_in;
      last_q <= in_i.last_in_block;
    end
    if (state_q == FrMul) begin
      prod_a_q <= $signed({1'b0, alpha_q}) * dc_q;
      prod_b_q <= $signed({1'b0, one_minus}) * x8;
    end
    if (state_q == FrSum) begin
      prod_c_q <= prior_q * $signed({1'b0, coef_q});
    end
  end

endmodule

[hdl/adpf_queue.sv]
// ----------------------------------------------------------------------------
// adpf_queue: short queue between front end and framer
// Holds conditioned samples with their frame-due flags.
// ----------------------------------------------------------------------------
module adpf_queue import adpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_entry_t push_data_i,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  output q_entry_t pop_data_o,
  output logic     pop_valid_o,
  input  logic     pop_ready_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  q_entry_t        entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/adpf_back.sv]
// ----------------------------------------------------------------------------
// adpf_back: sample ring and windowed frame emitter
// Writes conditioned samples to the ring and, for a due frame, streams the
// ring oldest first through the RMS-normalized Hann window.
// ----------------------------------------------------------------------------
module adpf_back import adpf_pkg::*; #(
  parameter int FRAME_LEN = FrameLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_entry_t  pop_data_i,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  adpf_out_if.source out_o
);

  localparam int          IdxW  = $clog2(FRAME_LEN);
  localparam int          Span  = FRAME_LEN - 1;
  localparam logic [63:0] PiQ30 = 64'd3373259426;
  localparam longint      OneQ30 = 64'sd1073741824;

  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2, term;
    longint      s;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    term = ((term * x2) >> 30) / 6;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 20;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 42;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 72;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 110;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 156;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 210;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 272;
    s    = s + longint'(term);
    if (s < 0) begin
      s = 0;
    end
    if (s > OneQ30) begin
      s = OneQ30;
    end
    return 64'(s);
  endfunction

  function automatic logic [63:0] hann_q16(input int n);
    logic [63:0] m, x, s, hv;
    m  = (2 * n > Span) ? 64'(Span - n) : 64'(n);
    x  = (PiQ30 * m) / Span;
    s  = sine_q30(x);
    hv = (s * s) >> 30;
    return (hv + 64'd8192) >> 14;
  endfunction

  function automatic logic [63:0] calc_rms();
    logic [63:0] energy, hv, v, res, bt;
    energy = '0;
    for (int n = 0; n < FRAME_LEN; n++) begin
      hv     = hann_q16(n);
      energy = energy + hv * hv;
    end
    v   = energy / FRAME_LEN;
    res = '0;
    bt  = 64'h1 << 62;
    while (bt > v) begin
      bt = bt >> 2;
    end
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  localparam logic [63:0] Rms    = calc_rms();
  localparam logic [63:0] RmsDiv = (Rms == 0) ? 64'd1 : Rms;

  function automatic logic [FRAME_LEN*16-1:0] build_rom();
    logic [FRAME_LEN*16-1:0] rom;
    logic [63:0]              hv, w;
    rom = '0;
    for (int n = 0; n < FRAME_LEN; n++) begin
      hv = hann_q16(n);
      if (Rms == 0) begin
        w = hv >> 2;
      end else begin
        w = (hv * 64'd16384 + Rms / 2) / RmsDiv;
      end
      if (w > 64'd65535) begin
        w = 64'd65535;
      end
      rom[n*16 +: 16] = w[15:0];
    end
    return rom;
  endfunction

  localparam logic [FRAME_LEN*16-1:0] WindowRom = build_rom();

  function automatic logic [IdxW-1:0] ptr_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(FRAME_LEN - 1)) ? '0 : p + 1'b1;
  endfunction

  logic signed [15:0] ring_mem [FRAME_LEN];

  bk_state_e state_q, state_d;

  logic [IdxW-1:0]    wp_q, rd_ptr_q, idx_q;
  logic               s1_v_q, s2_v_q, out_v_q;
  logic signed [15:0] rd_data_q;
  logic [IdxW-1:0]    s1_idx_q, s2_idx_q;
  logic signed [32:0] prod_q;
  logic signed [15:0] out_sample_q;
  logic [5:0]         out_idx_q;
  logic               out_last_q;

  logic               advance, issue, pop, last_issue;
  logic [15:0]        win;
  logic signed [33:0] rnd;

  assign advance    = !out_v_q || out_o.ready;
  assign pop        = pop_valid_i && pop_ready_o;
  assign last_issue = (idx_q == IdxW'(FRAME_LEN - 1));
  assign win        = WindowRom[s1_idx_q*16 +: 16];
  assign rnd        = {prod_q[32], prod_q} + 34'sd8192;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (pop && pop_data_i.due) begin
          state_d = BkEmit;
        end
      end
      BkEmit: begin
        if (issue && last_issue) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    pop_ready_o       = (state_q == BkIdle);
    issue             = (state_q == BkEmit) && advance;
    out_o.valid       = out_v_q;
    out_o.win_sample  = out_sample_q;
    out_o.frame_index = out_idx_q;
    out_o.frame_last  = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      wp_q     <= '0;
      rd_ptr_q <= '0;
      idx_q    <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        wp_q     <= ptr_inc(wp_q);
        rd_ptr_q <= ptr_inc(wp_q);
        idx_q    <= '0;
      end
      if (issue) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
        idx_q    <= idx_q + 1'b1;
      end
      if (advance) begin
        s1_v_q  <= issue;
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ring_mem[wp_q] <= pop_data_i.sample;
    end
    if (issue) begin
      rd_data_q <= ring_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q <= idx_q;
    end
    if (advance) begin
      prod_q       <= rd_data_q * $signed({1'b0, win});
      s2_idx_q     <= s1_idx_q;
      out_sample_q <= sat16(32'($signed(rnd[33:14])));
      out_idx_q    <= 6'(s2_idx_q);
      out_last_q   <= (s2_idx_q == IdxW'(FRAME_LEN - 1));
    end
  end

endmodule

[hdl/audio_dc_block_preemph_framer_unit.sv]
// ----------------------------------------------------------------------------
// audio_dc_block_preemph_framer_unit: DC blocker, pre-emphasis and framer
// In the front end a sample goes through accept, two multiply states and push
// (FrIdle, FrMul, FrSum, FrPush); the next waits until the queue takes it.
// A due frame streams FRAME_LEN results, one per cycle while out ready is high,
// via the ring read, product and output registers after its sample is popped.
// Reset clears all control state and loads the register defaults; no sweep.
// ----------------------------------------------------------------------------
module audio_dc_block_preemph_framer_unit import adpf_pkg::*; #(
  parameter int FRAME_LEN = FrameLenDef,
  parameter int HOP_LEN   = HopLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  adpf_in_if.sink             in_i,
  adpf_out_if.source          out_o
);

  cfg_wr_t  cfg_wr;
  q_entry_t push_data, pop_data;
  logic     push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  adpf_front #(
    .FRAME_LEN (FRAME_LEN),
    .HOP_LEN   (HOP_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .in_i         (in_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  adpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  adpf_back #(
    .FRAME_LEN (FRAME_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
